// ===== rtl/core/usqc_pkg.sv =====
// shared types, constants and decode functions for the smart quote converter
package usqc_pkg;

  localparam int unsigned CfgDataWidth = 21;
  localparam int unsigned CpWidth = 21;

  // configuration register indexes
  localparam logic CfgGermanMode    = 1'b0;
  localparam logic CfgContextBefore = 1'b1;

  localparam logic [7:0] AsciiDouble = 8'h22;
  localparam logic [7:0] AsciiSingle = 8'h27;

  // first two bytes of every three-byte typographic quote
  localparam logic [7:0] QuoteLead = 8'hE2;
  localparam logic [7:0] QuoteMid  = 8'h80;

  // low six bits of the quote codepoints, with the continuation marker
  localparam logic [7:0] LowDoubleLow9   = 8'h9E;  // U+201E
  localparam logic [7:0] LowDoubleLeft   = 8'h9C;  // U+201C
  localparam logic [7:0] LowDoubleRight  = 8'h9D;  // U+201D
  localparam logic [7:0] LowSingleLow9   = 8'h9A;  // U+201A
  localparam logic [7:0] LowSingleLeft   = 8'h98;  // U+2018
  localparam logic [7:0] LowSingleRight  = 8'h99;  // U+2019

  // tracking of the last emitted character
  typedef struct packed {
    logic [7:0]  lead;
    logic [1:0]  cnt;
    logic [17:0] tail;
    logic [1:0]  skip;
    logic        empty;
  } track_t;

  // one output run: a passed byte, or a quote with its final byte
  typedef struct packed {
    logic       quote;
    logic [7:0] data;
  } run_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    unique casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd1;
    endcase
  endfunction

  function automatic logic [CpWidth-1:0] previous_codepoint(
    input logic [7:0]  lead,
    input logic [1:0]  cnt,
    input logic [17:0] tail
  );
    logic [2:0]  len;
    logic [2:0]  k1;
    logic [2:0]  n;
    logic [1:0]  sh;
    logic [17:0] pay;
    len = lead_length(lead);
    k1  = {1'b0, cnt} + 3'd1;
    n   = (k1 < len) ? k1 : len;
    sh  = 2'(k1 - n);
    unique case (sh)
      2'd0: pay = tail;
      2'd1: pay = {6'b0, tail[17:6]};
      2'd2: pay = {12'b0, tail[17:12]};
      default: pay = '0;
    endcase
    unique case (n)
      3'd2: return {10'b0, lead[4:0], pay[5:0]};
      3'd3: return {5'b0, lead[3:0], pay[11:0]};
      3'd4: return {lead[2:0], pay};
      default: return {13'b0, lead};
    endcase
  endfunction

  function automatic logic opening_context(input logic [CpWidth-1:0] p);
    return p == 21'h0 || p == 21'h20 || p == 21'h0A || p == 21'h09 ||
           p == 21'h28 || p == 21'h5B || p == 21'h7B || p == 21'h2F ||
           p == 21'h2013 || p == 21'h2014 || p == 21'h201E ||
           p == 21'h201C || p == 21'h201A || p == 21'h2018;
  endfunction

endpackage

// ===== rtl/core/utf8_smart_quote_converter_top.sv =====
// Top level of the UTF-8 smart quote converter. Each request carries one
// byte; a byte passes through as one output byte, and a standalone ASCII
// quote becomes three bytes. A request is registered in the input register,
// decoded combinationally and loaded into the output run register, so passed
// bytes flow at one per cycle while the output is not stalled; a quote holds
// the output run register while its three bytes are sent, and the input
// register takes one more request meanwhile and then holds the input off until
// the last quote byte leaves. Configuration writes take effect at once and
// belong between strings while the block is idle.
module utf8_smart_quote_converter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [usqc_pkg::CfgDataWidth-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        data_byte,
  input  logic                              string_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic                              last_of_run
);

  logic                         german_mode;
  logic [usqc_pkg::CpWidth-1:0] context_before;

  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       ib_start;

  usqc_pkg::track_t state;
  usqc_pkg::track_t state_next;
  usqc_pkg::run_t   run;
  usqc_pkg::run_t   run_next;
  logic             run_valid;
  logic [1:0]       run_idx;

  logic run_free;
  logic load;

  assign out_valid   = run_valid;
  assign last_of_run = !run.quote || run_idx == 2'd2;
  assign run_free    = !run_valid || (out_ready && last_of_run);
  assign load        = ib_valid && run_free;
  assign in_ready    = !ib_valid || load;

  always_comb begin
    if (!run.quote) begin
      out_byte = run.data;
    end else begin
      unique case (run_idx)
        2'd0:    out_byte = usqc_pkg::QuoteLead;
        2'd1:    out_byte = usqc_pkg::QuoteMid;
        default: out_byte = run.data;
      endcase
    end
  end

  usqc_core u_core (
    .data_byte      (ib_byte),
    .string_start   (ib_start),
    .german_mode    (german_mode),
    .context_before (context_before),
    .state          (state),
    .state_next     (state_next),
    .run_next       (run_next)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      german_mode    <= 1'b0;
      context_before <= '0;
      ib_valid       <= 1'b0;
      run_valid      <= 1'b0;
      run_idx        <= 2'd0;
      state          <= '{lead: 8'h00, cnt: 2'd0, tail: 18'h0, skip: 2'd0, empty: 1'b1};
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          usqc_pkg::CfgGermanMode:    german_mode    <= cfg_data[0];
          usqc_pkg::CfgContextBefore: context_before <= cfg_data;
        endcase
      end
      if (in_ready) begin
        ib_valid <= in_valid;
      end
      if (load) begin
        state     <= state_next;
        run_valid <= 1'b1;
        run_idx   <= 2'd0;
      end else if (run_valid && out_ready) begin
        if (last_of_run) begin
          run_valid <= 1'b0;
        end else begin
          run_idx <= run_idx + 2'd1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ib_byte  <= data_byte;
      ib_start <= string_start;
    end
    if (load) begin
      run <= run_next;
    end
  end

endmodule

// ===== rtl/core/usqc_core.sv =====
// per-byte classification, quote selection and character tracking update
module usqc_core (
  input  logic [7:0]                    data_byte,
  input  logic                          string_start,
  input  logic                          german_mode,
  input  logic [usqc_pkg::CpWidth-1:0]  context_before,
  input  usqc_pkg::track_t              state,
  output usqc_pkg::track_t              state_next,
  output usqc_pkg::run_t                run_next
);

  usqc_pkg::track_t             cur;
  logic                         open_ctx;
  logic [usqc_pkg::CpWidth-1:0] prev_cp;

  always_comb begin
    cur = state;
    if (string_start) begin
      cur.skip  = 2'd0;
      cur.empty = 1'b1;
      cur.lead  = 8'h00;
      cur.cnt   = 2'd0;
      cur.tail  = 18'h0;
    end
  end

  assign prev_cp  = cur.empty ? context_before
                              : usqc_pkg::previous_codepoint(cur.lead, cur.cnt, cur.tail);
  assign open_ctx = usqc_pkg::opening_context(prev_cp);

  always_comb begin
    state_next     = cur;
    run_next.quote = 1'b0;
    run_next.data  = data_byte;
    if (cur.skip == 2'd0 &&
        (data_byte == usqc_pkg::AsciiDouble || data_byte == usqc_pkg::AsciiSingle)) begin
      run_next.quote = 1'b1;
      if (data_byte == usqc_pkg::AsciiDouble) begin
        if (open_ctx) begin
          run_next.data = german_mode ? usqc_pkg::LowDoubleLow9 : usqc_pkg::LowDoubleLeft;
        end else begin
          run_next.data = german_mode ? usqc_pkg::LowDoubleLeft : usqc_pkg::LowDoubleRight;
        end
      end else begin
        if (open_ctx) begin
          run_next.data = german_mode ? usqc_pkg::LowSingleLow9 : usqc_pkg::LowSingleLeft;
        end else begin
          run_next.data = usqc_pkg::LowSingleRight;
        end
      end
      // three bytes emitted: lead then two continuation bytes
      state_next.lead  = usqc_pkg::QuoteLead;
      state_next.cnt   = 2'd2;
      state_next.tail  = {12'b0, run_next.data[5:0]};
      state_next.empty = 1'b0;
    end else begin
      if (cur.skip != 2'd0) begin
        state_next.skip = cur.skip - 2'd1;
      end else begin
        state_next.skip = 2'(usqc_pkg::lead_length(data_byte) - 3'd1);
      end
      if (cur.empty || data_byte[7:6] != 2'b10) begin
        state_next.lead  = data_byte;
        state_next.cnt   = 2'd0;
        state_next.tail  = 18'h0;
        state_next.empty = 1'b0;
      end else if (cur.cnt != 2'd3) begin
        state_next.tail = {cur.tail[11:0], data_byte[5:0]};
        state_next.cnt  = cur.cnt + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/usqc_checker.sv =====
// port-level checks for the smart quote converter, bound to the top level
module usqc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // a stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output changed while stalled");

  // only a quote run spans several bytes
  a_multi_is_quote: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> out_byte == usqc_pkg::QuoteLead ||
                                  out_byte == usqc_pkg::QuoteMid)
    else $error("multi-byte run that is not a quote");

  a_quote_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run && out_byte == usqc_pkg::QuoteLead
    |=> out_valid && !last_of_run && out_byte == usqc_pkg::QuoteMid)
    else $error("quote lead not followed by middle byte");

  a_quote_third: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run && out_byte == usqc_pkg::QuoteMid
    |=> out_valid && last_of_run && out_byte[7:6] == 2'b10)
    else $error("quote run not closed by a continuation byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind utf8_smart_quote_converter_top usqc_checker u_usqc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);

// ===== tb/usqc_quote_checker.sv =====
// checker for the smart quote converter: predicts converted bytes per request and compares them
module usqc_quote_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        string_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        last_of_run,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_item_t;

  out_item_t   expected_bytes[$];
  out_item_t   want;

  logic        german;
  logic [20:0] ctx_before;
  logic [7:0]  lead_byte;
  logic [1:0]  cont_count;
  logic [17:0] cont_bits;
  logic [1:0]  skip_count;
  logic        nothing_sent;

  function automatic int seq_length(input logic [7:0] b);
    if (b[7] == 1'b0) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 1;
  endfunction

  // decode the last emitted character over the bytes seen so far
  function automatic logic [20:0] char_before(input logic [7:0] lead, input logic [1:0] cnt,
                                              input logic [17:0] bits);
    int          k;
    int          len;
    int          n;
    logic [17:0] shifted;
    k   = cnt;
    len = seq_length(lead);
    n   = (k + 1 < len) ? k + 1 : len;
    if (n <= 1) return {13'b0, lead};
    shifted = bits >> (6 * (k - n + 1));
    case (n)
      2: return {10'b0, lead[4:0], shifted[5:0]};
      3: return {5'b0, lead[3:0], shifted[11:0]};
      default: return {lead[2:0], shifted};
    endcase
  endfunction

  function automatic logic opens_quote(input logic [20:0] p);
    case (p)
      21'h0, 21'h20, 21'h0A, 21'h09, 21'h28, 21'h5B, 21'h7B, 21'h2F,
      21'h2013, 21'h2014, 21'h201E, 21'h201C, 21'h201A, 21'h2018: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit_byte(input logic [7:0] b, input logic last);
    out_item_t item;
    item = {b, last};
    expected_bytes.insert(expected_bytes.size(), item);
    if (nothing_sent || b[7:6] != 2'b10) begin
      lead_byte    = b;
      cont_count   = 2'd0;
      cont_bits    = '0;
      nothing_sent = 1'b0;
    end else if (cont_count < 2'd3) begin
      cont_bits  = {cont_bits[11:0], b[5:0]};
      cont_count = cont_count + 2'd1;
    end
  endtask

  task automatic convert_byte(input logic [7:0] b, input logic start);
    logic       open_form;
    logic [7:0] low;
    if (start) begin
      skip_count   = 2'd0;
      nothing_sent = 1'b1;
      lead_byte    = '0;
      cont_count   = 2'd0;
      cont_bits    = '0;
    end
    if (skip_count != 2'd0) begin
      skip_count = skip_count - 2'd1;
      emit_byte(b, 1'b1);
    end else if (b == usqc_pkg::AsciiDouble || b == usqc_pkg::AsciiSingle) begin
      open_form = opens_quote(nothing_sent ? ctx_before
                                           : char_before(lead_byte, cont_count, cont_bits));
      if (b == usqc_pkg::AsciiDouble)
        low = open_form ? (german ? usqc_pkg::LowDoubleLow9 : usqc_pkg::LowDoubleLeft)
                        : (german ? usqc_pkg::LowDoubleLeft : usqc_pkg::LowDoubleRight);
      else
        low = open_form ? (german ? usqc_pkg::LowSingleLow9 : usqc_pkg::LowSingleLeft)
                        : usqc_pkg::LowSingleRight;
      emit_byte(usqc_pkg::QuoteLead, 1'b0);
      emit_byte(usqc_pkg::QuoteMid, 1'b0);
      emit_byte(low, 1'b1);
    end else begin
      skip_count = 2'(seq_length(b) - 1);
      emit_byte(b, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      german       = 1'b0;
      ctx_before   = '0;
      lead_byte    = '0;
      cont_count   = 2'd0;
      cont_bits    = '0;
      skip_count   = 2'd0;
      nothing_sent = 1'b1;
      expected_bytes.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          usqc_pkg::CfgGermanMode:    german = cfg_data[0];
          usqc_pkg::CfgContextBefore: ctx_before = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: output byte %02h last %0b with nothing expected",
                   $time, out_byte, last_of_run);
          errors = errors + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.value, out_byte);
            errors = errors + 1;
          end
          if (last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last, last_of_run);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && in_ready) convert_byte(data_byte, string_start);
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== tb/tb_utf8_smart_quote_converter_top.sv =====
// testbench top for the smart quote converter: request stimulus, output stalls and verdict
module tb_utf8_smart_quote_converter_top;

  logic                              clk;
  logic                              rst;
  logic                              cfg_write;
  logic                              cfg_index;
  logic [usqc_pkg::CfgDataWidth-1:0] cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [7:0]                        data_byte;
  logic                              string_start;
  logic                              out_valid;
  logic                              out_ready;
  logic [7:0]                        out_byte;
  logic                              last_of_run;

  int errors;
  int pending;
  int idle_cycles = 0;
  int requests_sent = 0;
  bit steady_send = 1'b0;
  bit hold_request = 1'b0;
  bit holding = 1'b0;

  utf8_smart_quote_converter_top dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .string_start(string_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_of_run(last_of_run)
  );

  usqc_quote_checker quote_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .string_start(string_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_of_run(last_of_run),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no request moving on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic int send_gap();
    int r;
    if (steady_send || holding) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    string_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent = requests_sent + 1;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [usqc_pkg::CfgDataWidth-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic g, input logic [usqc_pkg::CfgDataWidth-1:0] ctx);
    write_reg(usqc_pkg::CfgGermanMode, {20'b0, g});
    write_reg(usqc_pkg::CfgContextBefore, ctx);
  endtask

  function automatic logic [usqc_pkg::CfgDataWidth-1:0] pick_context();
    case ($urandom_range(0, 7))
      0: return 21'h0;
      1: return 21'h20;
      2: return 21'h2014;
      3: return 21'h201C;
      4: return 21'h1FFFFF;
      5: return 21'h41;
      default: return 21'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  // one character of text, mostly well formed, sometimes broken or noise
  task automatic send_text_char(input logic begin_str);
    logic [7:0] seq [0:3];
    int         kind;
    int         n;
    int         len;
    kind = $urandom_range(0, 99);
    n    = 1;
    if (kind < 22) begin
      seq[0] = $urandom_range(0, 1) ? usqc_pkg::AsciiDouble : usqc_pkg::AsciiSingle;
    end else if (kind < 37) begin
      case ($urandom_range(0, 6))
        0: seq[0] = 8'h20;
        1: seq[0] = 8'h0A;
        2: seq[0] = 8'h09;
        3: seq[0] = 8'h28;
        4: seq[0] = 8'h5B;
        5: seq[0] = 8'h7B;
        default: seq[0] = 8'h2F;
      endcase
    end else if (kind < 55) begin
      seq[0] = 8'($urandom_range(0, 8'h7F));
    end else if (kind < 65) begin
      n      = 3;
      seq[0] = usqc_pkg::QuoteLead;
      seq[1] = usqc_pkg::QuoteMid;
      case ($urandom_range(0, 7))
        0: seq[2] = 8'h93;
        1: seq[2] = 8'h94;
        2: seq[2] = usqc_pkg::LowDoubleLow9;
        3: seq[2] = usqc_pkg::LowDoubleLeft;
        4: seq[2] = usqc_pkg::LowDoubleRight;
        5: seq[2] = usqc_pkg::LowSingleLow9;
        6: seq[2] = usqc_pkg::LowSingleLeft;
        default: seq[2] = usqc_pkg::LowSingleRight;
      endcase
    end else if (kind < 90) begin
      len = $urandom_range(2, 4);
      case (len)
        2: seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
        3: seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
        default: seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
      endcase
      for (int i = 1; i < 4; i++) seq[i] = 8'($urandom_range(8'h80, 8'hBF));
      n = len;
      // truncated sequence
      if (kind >= 77 && kind < 85) n = $urandom_range(1, len - 1);
      // quote inside a sequence, to be passed through
      if (kind >= 85) seq[$urandom_range(1, len - 1)] =
          $urandom_range(0, 1) ? usqc_pkg::AsciiDouble : usqc_pkg::AsciiSingle;
    end else begin
      seq[0] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < n; i++) send_byte(seq[i], begin_str && i == 0);
  endtask

  // receiver: short and long stalls, bursts, and one long hold-off
  initial begin
    int run;
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holding      = 1'b1;
        out_ready <= 1'b0;
        repeat (100) @(negedge clk);
        holding = 1'b0;
      end
      run = ($urandom_range(0, 99) < 30) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      stall = $urandom_range(0, 99);
      stall = (stall < 40) ? 0 : (stall < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    int phase_start;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = usqc_pkg::CfgGermanMode;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    string_start = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // english, start of text
    set_config(1'b0, 21'h0);
    send_byte(usqc_pkg::AsciiDouble, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(usqc_pkg::AsciiDouble, 1'b0);
    send_byte(usqc_pkg::AsciiSingle, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(usqc_pkg::AsciiSingle, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(usqc_pkg::AsciiDouble, 1'b0);
    send_byte(usqc_pkg::QuoteLead, 1'b0);
    send_byte(usqc_pkg::QuoteMid, 1'b0);
    send_byte(8'h93, 1'b0);
    send_byte(usqc_pkg::AsciiDouble, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(usqc_pkg::AsciiDouble, 1'b0);
    send_byte(usqc_pkg::AsciiSingle, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(usqc_pkg::AsciiDouble, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    wait_idle();

    // german, out of range context; a new string cuts a sequence
    set_config(1'b1, 21'h1FFFFF);
    send_byte(usqc_pkg::AsciiSingle, 1'b1);
    send_byte(usqc_pkg::AsciiDouble, 1'b0);
    send_byte(usqc_pkg::QuoteLead, 1'b1);
    send_byte(usqc_pkg::AsciiDouble, 1'b1);
    wait_idle();

    set_config(1'b1, 21'h20);
    send_byte(usqc_pkg::AsciiDouble, 1'b1);
    send_byte(usqc_pkg::AsciiSingle, 1'b0);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(1'b1, 21'h1FFFFF);
        1: set_config(1'b0, 21'h0);
        default: set_config(1'($urandom_range(0, 1)), pick_context());
      endcase
      // receiver holds off while the requests keep coming
      if (phase == 1) begin
        hold_request = 1'b1;
        wait (holding);
      end
      phase_start = requests_sent;
      send_text_char(1'b1);
      while (requests_sent - phase_start < 50) begin
        if ($urandom_range(0, 29) == 0) steady_send = ~steady_send;
        send_text_char($urandom_range(0, 9) == 0);
      end
      steady_send = 1'b0;
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== utf8_smart_quote_converter_top.f =====
rtl/core/usqc_pkg.sv
rtl/core/usqc_core.sv
rtl/core/utf8_smart_quote_converter_top.sv
rtl/core/usqc_checker.sv
tb/usqc_quote_checker.sv
tb/tb_utf8_smart_quote_converter_top.sv
